// ----- hdl/qsfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query string field decoder package
// Shared constants, result type and hex digit helper for the decoder.
// ----------------------------------------------------------------------------
package qsfd_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W = 12;
   localparam int NIBBLE_W = 4;

   localparam int MAX_FIELD_LEN = 4095;
   localparam int LEN_MAX_CODE = (1 << LEN_W) - 1;
   localparam logic [LEN_W-1:0] LEN_CAP =
      LEN_W'((MAX_FIELD_LEN > LEN_MAX_CODE) ? LEN_MAX_CODE : MAX_FIELD_LEN);

   localparam int RESULT_QUEUE_DEPTH = 4;

   localparam logic [BYTE_W-1:0] CHAR_PLUS = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CHAR_AMP = 8'h26;
   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [NIBBLE_W-1:0] HEX_LETTER_BASE = 4'd10;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_HIGH = 2'd1,
      PHASE_LOW  = 2'd2
   } phase_type;

   typedef enum logic {
      KIND_DATA      = 1'b0,
      KIND_FIELD_END = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type             result_kind;
      logic [BYTE_W-1:0]    data_byte;
      logic [LEN_W-1:0]     field_length;
      logic                 escape_error;
      logic                 last_field;
   } result_type;

   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } push_type;

   // 'a'..'f' count from 'a', other bytes >= 'A' from 'A', the rest from '0'.
   function automatic logic [NIBBLE_W-1:0] digit_value(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] base;
      begin
         if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            base = CHAR_LOWER_A;
         end else if (c >= CHAR_UPPER_A) begin
            base = CHAR_UPPER_A;
         end else begin
            base = CHAR_ZERO;
         end
         if (base == CHAR_ZERO) begin
            digit_value = NIBBLE_W'(c - base);
         end else begin
            digit_value = NIBBLE_W'(c - base) + HEX_LETTER_BASE;
         end
      end
   endfunction

endpackage

// ----- hdl/qsfd_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query string field decoder: byte decode stage
// Holds the escape and field state and turns each request into up to two
// results for the result queue.
// ----------------------------------------------------------------------------
module qsfd_decode (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [qsfd_pkg::BYTE_W-1:0]       in_byte,
   input  logic                              end_of_string,
   output qsfd_pkg::push_type                push
);

   qsfd_pkg::phase_type                phase_ff, phase_in;
   logic [qsfd_pkg::NIBBLE_W-1:0]      high_ff, high_in;
   logic [qsfd_pkg::LEN_W-1:0]         length_ff, length_in;
   logic                               error_ff, error_in;

   qsfd_pkg::phase_type                phase_next;
   logic [qsfd_pkg::NIBBLE_W-1:0]      high_next;
   logic [qsfd_pkg::NIBBLE_W-1:0]      digit;
   logic [qsfd_pkg::BYTE_W-1:0]        escaped;
   logic                               data_valid;
   logic [qsfd_pkg::BYTE_W-1:0]        data_value;
   logic [qsfd_pkg::LEN_W-1:0]         length_next;
   logic                               end_valid;
   logic                               end_error;
   logic                               end_last;
   logic [qsfd_pkg::LEN_W-1:0]         end_length;
   qsfd_pkg::result_type               data_res;
   qsfd_pkg::result_type               end_res;

   always_comb begin
      digit = qsfd_pkg::digit_value(in_byte);
      escaped = {high_ff, digit};
      phase_next = phase_ff;
      high_next = high_ff;
      data_valid = 1'b0;
      data_value = in_byte;
      end_valid = 1'b0;
      end_last = end_of_string;
      end_error = error_ff;
      end_length = length_ff;
      length_next = length_ff;

      if (in_byte == qsfd_pkg::CHAR_AMP) begin
         end_valid = 1'b1;
         end_error = error_ff | (phase_ff != qsfd_pkg::PHASE_IDLE);
      end else begin
         case (phase_ff)
            qsfd_pkg::PHASE_HIGH: begin
               high_next = digit;
               phase_next = qsfd_pkg::PHASE_LOW;
            end
            qsfd_pkg::PHASE_LOW: begin
               phase_next = qsfd_pkg::PHASE_IDLE;
               high_next = '0;
               data_value = escaped;
               data_valid = (escaped != qsfd_pkg::CHAR_CR);
            end
            default: begin
               if (in_byte == qsfd_pkg::CHAR_PERCENT) begin
                  phase_next = qsfd_pkg::PHASE_HIGH;
               end else if (in_byte == qsfd_pkg::CHAR_PLUS) begin
                  data_valid = 1'b1;
                  data_value = qsfd_pkg::CHAR_SPACE;
               end else begin
                  data_valid = 1'b1;
               end
            end
         endcase
         if (data_valid && length_ff < qsfd_pkg::LEN_CAP) begin
            length_next = length_ff + 1'b1;
         end
         end_valid = end_of_string;
         end_last = 1'b1;
         end_length = length_next;
         end_error = error_ff | (phase_next != qsfd_pkg::PHASE_IDLE);
      end

      data_res = '{result_kind: qsfd_pkg::KIND_DATA, data_byte: data_value,
                   field_length: '0, escape_error: 1'b0, last_field: 1'b0};
      end_res = '{result_kind: qsfd_pkg::KIND_FIELD_END, data_byte: '0,
                  field_length: end_length, escape_error: end_error,
                  last_field: end_last};

      push.first = data_valid ? data_res : end_res;
      push.second = end_res;
      push.count = accept ? ({1'b0, data_valid} + {1'b0, end_valid}) : 2'd0;

      phase_in = phase_ff;
      high_in = high_ff;
      length_in = length_ff;
      error_in = error_ff;
      if (accept) begin
         if (end_valid) begin
            phase_in = qsfd_pkg::PHASE_IDLE;
            high_in = '0;
            length_in = '0;
            error_in = 1'b0;
         end else begin
            phase_in = phase_next;
            high_in = high_next;
            length_in = length_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= qsfd_pkg::PHASE_IDLE;
         high_ff <= '0;
         length_ff <= '0;
         error_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         high_ff <= high_in;
         length_ff <= length_in;
         error_ff <= error_in;
      end
   end

endmodule

// ----- hdl/qsfd_result_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query string field decoder: result queue
// Register queue that takes up to two results a cycle and hands one out.
// ----------------------------------------------------------------------------
module qsfd_result_queue #(
   parameter int DEPTH = qsfd_pkg::RESULT_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  qsfd_pkg::push_type    push,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_stall,
   output qsfd_pkg::result_type  out_result
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   qsfd_pkg::result_type  entry_ff [DEPTH];
   logic [PW-1:0]         wr_ff, wr_in;
   logic [PW-1:0]         rd_ff, rd_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [PW-1:0]         wr_next;
   logic                  pop;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      begin
         ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
      end
   endfunction

   always_comb begin
      wr_next = ptr_inc(wr_ff);
      out_valid = (count_ff != '0);
      pop = out_valid && !out_stall;
      out_result = entry_ff[rd_ff];
      room = (count_ff <= CW'(DEPTH - 2));
      rd_in = pop ? ptr_inc(rd_ff) : rd_ff;
      case (push.count)
         2'd1: wr_in = wr_next;
         2'd2: wr_in = ptr_inc(wr_next);
         default: wr_in = wr_ff;
      endcase
      count_in = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

// ----- hdl/query_string_field_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query string field decoder
// Decodes a form-urlencoded query string into data bytes and field ends.
// ----------------------------------------------------------------------------
// Usage:
// The request channel takes one raw byte a cycle with end_of_string set on the
// final byte. A request is taken when req_valid is high and req_stall is low.
// Each request gives no result, one result, or a decoded byte followed by a
// field end. Results are registered in the result queue and leave one a
// cycle while rsp_stall is low. Throughput is one request per cycle while
// the queue has room; a request that gives two results fills two queue
// slots, so a long run of those is held to the rate at which results leave.
// The rate is set by the single output port of the result queue.
// The request side stalls whenever the queue lacks room for two results.
// While the receiver stalls, the response held on the ports does not change.
// Reset clears the escape state, the field length and the queue. The request
// side stalls while reset is high, and a request can be taken from the first
// cycle after reset.
// ----------------------------------------------------------------------------
module query_string_field_decoder #(
   parameter int RESULT_QUEUE_DEPTH = qsfd_pkg::RESULT_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [qsfd_pkg::BYTE_W-1:0]    req_in_byte,
   input  logic                           req_end_of_string,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_result_kind,
   output logic [qsfd_pkg::BYTE_W-1:0]    rsp_data_byte,
   output logic [qsfd_pkg::LEN_W-1:0]     rsp_field_length,
   output logic                           rsp_escape_error,
   output logic                           rsp_last_field
);

   qsfd_pkg::push_type    push;
   qsfd_pkg::result_type  result;
   logic                  room;
   logic                  accept;

   assign req_stall = reset || !room;
   assign accept = req_valid && !req_stall;

   qsfd_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .end_of_string (req_end_of_string),
      .push          (push)
   );

   qsfd_result_queue #(
      .DEPTH (RESULT_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (result)
   );

   assign rsp_result_kind = result.result_kind;
   assign rsp_data_byte = result.data_byte;
   assign rsp_field_length = result.field_length;
   assign rsp_escape_error = result.escape_error;
   assign rsp_last_field = result.last_field;

endmodule

// ----- hdl/qsfd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query string field decoder checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module qsfd_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [qsfd_pkg::BYTE_W-1:0]    req_in_byte,
   input  logic                           req_end_of_string,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_result_kind,
   input  logic [qsfd_pkg::BYTE_W-1:0]    rsp_data_byte,
   input  logic [qsfd_pkg::LEN_W-1:0]     rsp_field_length,
   input  logic                           rsp_escape_error,
   input  logic                           rsp_last_field
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind) &&
      $stable(rsp_data_byte) && $stable(rsp_field_length) &&
      $stable(rsp_escape_error) && $stable(rsp_last_field))
      else $error("stalled response changed");

   a_field_end_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_in_byte == qsfd_pkg::CHAR_AMP || req_end_of_string) |=> rsp_valid)
      else $error("field end missing after closing request");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == qsfd_pkg::KIND_DATA |->
      rsp_field_length == '0 && !rsp_escape_error && !rsp_last_field)
      else $error("data result carries field end information");

   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == qsfd_pkg::KIND_FIELD_END |->
      rsp_data_byte == '0)
      else $error("field end carries a data byte");

endmodule

bind query_string_field_decoder qsfd_checker u_qsfd_checker (.*);

// ----- tb/query_string_field_decoder_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query string field decoder checker
// Watches the request and response channels of the decoder. It decodes every
// accepted request byte with its own model of the escape and field state,
// queues the results that byte should give, and compares each accepted
// response field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module query_string_field_decoder_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [qsfd_pkg::BYTE_W-1:0]    req_in_byte,
   input  logic                           req_end_of_string,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_result_kind,
   input  logic [qsfd_pkg::BYTE_W-1:0]    rsp_data_byte,
   input  logic [qsfd_pkg::LEN_W-1:0]     rsp_field_length,
   input  logic                           rsp_escape_error,
   input  logic                           rsp_last_field,
   output int                             mismatch_count,
   output int                             results_pending
);

   qsfd_pkg::phase_type            escape_phase;
   logic [qsfd_pkg::NIBBLE_W-1:0]  high_nibble;
   logic [qsfd_pkg::LEN_W-1:0]     field_length;
   logic                           field_error;
   qsfd_pkg::result_type           decoded_results_due[$];

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < 100) begin
         $display("mismatch at %0t: %s is %0h, expected %0h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   function automatic logic [qsfd_pkg::NIBBLE_W-1:0] hex_value(
      input logic [qsfd_pkg::BYTE_W-1:0] c);
      logic [qsfd_pkg::BYTE_W-1:0] v;
      if (c >= qsfd_pkg::CHAR_LOWER_A && c <= qsfd_pkg::CHAR_LOWER_F) begin
         v = c - qsfd_pkg::CHAR_LOWER_A + qsfd_pkg::BYTE_W'(qsfd_pkg::HEX_LETTER_BASE);
      end else if (c >= qsfd_pkg::CHAR_UPPER_A) begin
         v = c - qsfd_pkg::CHAR_UPPER_A + qsfd_pkg::BYTE_W'(qsfd_pkg::HEX_LETTER_BASE);
      end else begin
         v = c - qsfd_pkg::CHAR_ZERO;
      end
      return v[qsfd_pkg::NIBBLE_W-1:0];
   endfunction

   task automatic emit_byte(input logic [qsfd_pkg::BYTE_W-1:0] b);
      qsfd_pkg::result_type r;
      r = '0;
      r.result_kind = qsfd_pkg::KIND_DATA;
      r.data_byte = b;
      decoded_results_due.push_back(r);
      if (field_length < qsfd_pkg::LEN_CAP) begin
         field_length++;
      end
   endtask

   task automatic close_field(input logic closes);
      qsfd_pkg::result_type r;
      r = '0;
      r.result_kind = qsfd_pkg::KIND_FIELD_END;
      r.field_length = field_length;
      r.escape_error = field_error;
      r.last_field = closes;
      decoded_results_due.push_back(r);
      escape_phase = qsfd_pkg::PHASE_IDLE;
      high_nibble = '0;
      field_length = '0;
      field_error = 1'b0;
   endtask

   task automatic decode_byte(input logic [qsfd_pkg::BYTE_W-1:0] c, input logic closes);
      logic [qsfd_pkg::BYTE_W-1:0] decoded;
      if (c == qsfd_pkg::CHAR_AMP) begin
         if (escape_phase != qsfd_pkg::PHASE_IDLE) begin
            field_error = 1'b1;
         end
         close_field(closes);
         return;
      end
      case (escape_phase)
         qsfd_pkg::PHASE_HIGH: begin
            high_nibble = hex_value(c);
            escape_phase = qsfd_pkg::PHASE_LOW;
         end
         qsfd_pkg::PHASE_LOW: begin
            decoded = {high_nibble, hex_value(c)};
            escape_phase = qsfd_pkg::PHASE_IDLE;
            high_nibble = '0;
            if (decoded != qsfd_pkg::CHAR_CR) begin
               emit_byte(decoded);
            end
         end
         default: begin
            if (c == qsfd_pkg::CHAR_PERCENT) begin
               escape_phase = qsfd_pkg::PHASE_HIGH;
            end else if (c == qsfd_pkg::CHAR_PLUS) begin
               emit_byte(qsfd_pkg::CHAR_SPACE);
            end else begin
               emit_byte(c);
            end
         end
      endcase
      if (closes) begin
         if (escape_phase != qsfd_pkg::PHASE_IDLE) begin
            field_error = 1'b1;
         end
         close_field(1'b1);
      end
   endtask

   task automatic check_response();
      qsfd_pkg::result_type want;
      if (decoded_results_due.size() == 0) begin
         report_mismatch("response with none outstanding, kind", rsp_result_kind, 0);
         return;
      end
      want = decoded_results_due.pop_front();
      if (rsp_result_kind !== want.result_kind) begin
         report_mismatch("result_kind", rsp_result_kind, want.result_kind);
      end
      if (rsp_data_byte !== want.data_byte) begin
         report_mismatch("data_byte", rsp_data_byte, want.data_byte);
      end
      if (rsp_field_length !== want.field_length) begin
         report_mismatch("field_length", rsp_field_length, want.field_length);
      end
      if (rsp_escape_error !== want.escape_error) begin
         report_mismatch("escape_error", rsp_escape_error, want.escape_error);
      end
      if (rsp_last_field !== want.last_field) begin
         report_mismatch("last_field", rsp_last_field, want.last_field);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         escape_phase = qsfd_pkg::PHASE_IDLE;
         high_nibble = '0;
         field_length = '0;
         field_error = 1'b0;
         decoded_results_due.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            check_response();
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            decode_byte(req_in_byte, req_end_of_string);
         end
      end
      results_pending = decoded_results_due.size();
   end

endmodule

// ----- tb/query_string_field_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query string field decoder testbench
// Drives the decoder with a short directed set of query strings covering
// escapes, cut escapes, empty and trailing fields, then with random strings,
// mostly well formed and some noise. Both sides idle at random; a checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module query_string_field_decoder_tb;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [qsfd_pkg::BYTE_W-1:0]    req_in_byte = '0;
   logic                           req_end_of_string = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_result_kind;
   logic [qsfd_pkg::BYTE_W-1:0]    rsp_data_byte;
   logic [qsfd_pkg::LEN_W-1:0]     rsp_field_length;
   logic                           rsp_escape_error;
   logic                           rsp_last_field;
   int                             mismatch_count;
   int                             results_pending;

   int                             bytes_sent = 0;
   int                             strings_sent = 0;
   bit                             steady_sender = 1'b0;

   query_string_field_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_field_length  (rsp_field_length),
      .rsp_escape_error  (rsp_escape_error),
      .rsp_last_field    (rsp_last_field)
   );

   query_string_field_decoder_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_field_length  (rsp_field_length),
      .rsp_escape_error  (rsp_escape_error),
      .rsp_last_field    (rsp_last_field),
      .mismatch_count    (mismatch_count),
      .results_pending   (results_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // The receiver holds off twice for a long stretch, so that the result queue
   // fills and the request side stalls, and has one stretch with no idling.
   initial begin
      int cycle_count;
      int hold_left;
      cycle_count = 0;
      hold_left = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count == 400 || cycle_count == 3000) begin
            hold_left = 150;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (cycle_count >= 1200 && cycle_count < 1900) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 36);
         end
      end
   end

   task automatic send_request(input logic [qsfd_pkg::BYTE_W-1:0] b, input logic closes);
      while (!steady_sender && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_end_of_string <= closes;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   task automatic send_query(input logic [qsfd_pkg::BYTE_W-1:0] text[$]);
      foreach (text[i]) begin
         send_request(text[i], i == text.size() - 1);
      end
      strings_sent++;
   endtask

   task automatic send_text(input string s, input logic closes);
      for (int i = 0; i < s.len(); i++) begin
         send_request(s[i], closes && i == s.len() - 1);
      end
   endtask

   function automatic logic [qsfd_pkg::BYTE_W-1:0] hex_char(
      input logic [qsfd_pkg::NIBBLE_W-1:0] n, input bit upper);
      if (n < qsfd_pkg::HEX_LETTER_BASE) begin
         return qsfd_pkg::CHAR_ZERO + qsfd_pkg::BYTE_W'(n);
      end
      return (upper ? qsfd_pkg::CHAR_UPPER_A : qsfd_pkg::CHAR_LOWER_A) +
             qsfd_pkg::BYTE_W'(n - qsfd_pkg::HEX_LETTER_BASE);
   endfunction

   function automatic logic [qsfd_pkg::BYTE_W-1:0] plain_char();
      logic [qsfd_pkg::BYTE_W-1:0] b;
      case ($urandom_range(2))
         0: b = qsfd_pkg::CHAR_LOWER_A + qsfd_pkg::BYTE_W'($urandom_range(25));
         1: b = qsfd_pkg::CHAR_UPPER_A + qsfd_pkg::BYTE_W'($urandom_range(25));
         default: b = qsfd_pkg::CHAR_ZERO + qsfd_pkg::BYTE_W'($urandom_range(9));
      endcase
      return b;
   endfunction

   task automatic send_random_query();
      logic [qsfd_pkg::BYTE_W-1:0] text[$];
      logic [qsfd_pkg::BYTE_W-1:0] b;
      int                          fields;
      int                          roll;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(20, 1)) begin
            text.push_back(qsfd_pkg::BYTE_W'($urandom_range(255)));
         end
      end else begin
         fields = $urandom_range(4, 1);
         for (int f = 0; f < fields; f++) begin
            if (f > 0) begin
               text.push_back(qsfd_pkg::CHAR_AMP);
            end
            repeat ($urandom_range(10)) begin
               roll = $urandom_range(99);
               if (roll < 40) begin
                  text.push_back(plain_char());
               end else if (roll < 55) begin
                  text.push_back(qsfd_pkg::CHAR_PLUS);
               end else if (roll < 85) begin
                  b = ($urandom_range(7) == 0) ? qsfd_pkg::CHAR_CR :
                      qsfd_pkg::BYTE_W'($urandom_range(255));
                  text.push_back(qsfd_pkg::CHAR_PERCENT);
                  text.push_back(hex_char(b[7:4], 1'($urandom_range(1))));
                  text.push_back(hex_char(b[3:0], 1'($urandom_range(1))));
               end else begin
                  do begin
                     b = qsfd_pkg::BYTE_W'($urandom_range(255));
                  end while (b == qsfd_pkg::CHAR_AMP || b == qsfd_pkg::CHAR_PERCENT);
                  text.push_back(b);
               end
            end
            if ($urandom_range(99) < 6) begin
               text.push_back(qsfd_pkg::CHAR_PERCENT);
               if ($urandom_range(1)) begin
                  text.push_back(hex_char(qsfd_pkg::NIBBLE_W'($urandom_range(15)),
                                          1'($urandom_range(1))));
               end
            end
         end
         if (text.size() == 0 || $urandom_range(99) < 20) begin
            text.push_back(qsfd_pkg::CHAR_AMP);
         end
      end
      send_query(text);
   endtask

   initial begin
      int random_start;
      bit paused;
      paused = 1'b0;
      wait (!reset);
      @(posedge clock);

      // Directed strings: a lone ampersand, every escape form with both digit
      // cases, a dropped encoded carriage return beside a kept raw one, a NUL,
      // empty fields, escapes cut by an ampersand and by the end of the
      // string, non-hex digits and a final data byte.
      send_text("&", 1'b1);
      send_text("%41%fF+", 1'b0);
      send_request(8'h00, 1'b0);
      send_text("%0d", 1'b0);
      send_request(qsfd_pkg::CHAR_CR, 1'b0);
      send_text("&&%Z&%&%zG", 1'b0);
      send_request(8'hFF, 1'b0);
      send_text("&%4", 1'b1);
      send_text("x", 1'b1);
      send_text("%", 1'b1);
      send_text("%41", 1'b1);
      strings_sent += 5;

      req_valid <= 1'b0;
      wait (results_pending == 0);
      @(posedge clock);

      random_start = bytes_sent;
      while (bytes_sent - random_start < 1600) begin
         steady_sender = (bytes_sent - random_start >= 600 &&
                          bytes_sent - random_start < 900);
         if (!paused && bytes_sent - random_start >= 800) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            wait (results_pending == 0);
            @(posedge clock);
         end
         send_random_query();
      end
      steady_sender = 1'b0;
      req_valid <= 1'b0;

      wait (results_pending == 0);
      repeat (16) @(posedge clock);
      $display("Sent %0d request bytes in %0d query strings under random idling,",
               bytes_sent, strings_sent);
      $display("with cut escapes, empty fields, noise and long receiver stalls.");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
